@@ rtl/superio_config_register_block_assert.svh @@
// Assertion macros for the super I/O configuration register block.
// Included by the modules that assert; no other dependencies.
`ifndef SUPERIO_CONFIG_REGISTER_BLOCK_ASSERT_SVH
`define SUPERIO_CONFIG_REGISTER_BLOCK_ASSERT_SVH

`ifndef SYNTHESIS
`define SIOCFG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("siocfg assertion failed");
`define SIOCFG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("siocfg assertion failed");
`else
`define SIOCFG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SIOCFG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/siocfg_pkg.sv @@
// Shared types, register indexes, reset defaults and base-address tables
// for the super I/O configuration register block. No dependencies.
package siocfg_pkg;

  localparam int unsigned IDX_BITS = 5;

  // register indexes with special handling
  localparam logic [IDX_BITS-1:0] IDX_FER     = 5'h00;  // function enables
  localparam logic [IDX_BITS-1:0] IDX_FAR     = 5'h01;  // address select
  localparam logic [IDX_BITS-1:0] IDX_PTR     = 5'h02;  // power-down
  localparam logic [IDX_BITS-1:0] IDX_SID     = 5'h08;  // chip id, read-only
  localparam logic [IDX_BITS-1:0] IDX_LPT_REL = 5'h19;  // relocated parallel base
  localparam logic [IDX_BITS-1:0] IDX_CTRL    = 5'h1B;  // relocation unlock
  localparam logic [IDX_BITS-1:0] IDX_IRQ_SEL = 5'h1C;  // serial irq override

  localparam logic [7:0] CHIP_ID         = 8'h70;
  localparam logic [7:0] FER_MASK        = 8'h5F;
  localparam logic [7:0] FER_DEFAULT     = 8'h4B;
  localparam logic [7:0] FER_ALIAS       = 8'h08;  // byte that maps to the default
  localparam logic [7:0] LPT_REL_DEFAULT = 8'hEF;
  localparam logic [7:0] NO_REG_DATA     = 8'hFF;
  localparam int unsigned UNLOCK_BIT     = 6;

  localparam logic [9:0] LPT_BASE_0 = 10'h378;
  localparam logic [9:0] LPT_BASE_1 = 10'h3BC;
  localparam logic [9:0] LPT_BASE_2 = 10'h278;
  localparam logic [9:0] COM_BASE_0 = 10'h3F8;
  localparam logic [9:0] COM_BASE_1 = 10'h2F8;
  localparam logic [9:0] FDC_PRI    = 10'h3F0;
  localparam logic [9:0] FDC_SEC    = 10'h370;
  localparam logic [2:0] IRQ_3      = 3'd3;
  localparam logic [2:0] IRQ_4      = 3'd4;

  localparam logic [9:0] ALT_BASE_A [4] = '{10'h3E8, 10'h338, 10'h2E8, 10'h220};
  localparam logic [9:0] ALT_BASE_B [4] = '{10'h2E8, 10'h238, 10'h2E0, 10'h228};

  // chip defaults, one byte per register index
  localparam logic [7:0] REG_DEFAULTS [32] = '{
    FER_DEFAULT, 8'h01, 8'h00, 8'h01, 8'h00, 8'h0D, 8'h00, 8'h00,
    CHIP_ID,     8'hC0, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h1E,
    8'h00,       8'h00, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, LPT_REL_DEFAULT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // register bytes the unit decode looks at
  typedef struct packed {
    logic [7:0] fer;
    logic [7:0] far;
    logic [7:0] ptr;
    logic [7:0] lpt_rel;
    logic [7:0] ctrl;
    logic [7:0] irq_sel;
  } cfg_view_t;

  typedef struct packed {
    logic       lpt_on;
    logic [9:0] lpt_base;
    logic       com1_on;
    logic [9:0] com1_base;
    logic [2:0] com1_irq;
    logic       com2_on;
    logic [9:0] com2_base;
    logic [2:0] com2_irq;
    logic       fdc_on;
    logic [9:0] fdc_base;
  } unit_map_t;

  function automatic logic [7:0] reg_default(input logic [IDX_BITS-1:0] idx);
    return REG_DEFAULTS[idx];
  endfunction

  function automatic logic [9:0] serial_base(input logic [1:0] sel, input logic [1:0] ext);
    logic [9:0] base;
    unique case (sel)
      2'd0:    base = COM_BASE_0;
      2'd1:    base = COM_BASE_1;
      2'd2:    base = ALT_BASE_A[ext];
      default: base = ALT_BASE_B[ext];
    endcase
    return base;
  endfunction

endpackage

@@ rtl/siocfg_decode.sv @@
// Decodes the configuration bytes into unit enables, bases and irqs.
// Depends on siocfg_pkg.
module siocfg_decode (
  input  siocfg_pkg::cfg_view_t regs,
  output siocfg_pkg::unit_map_t units
);

  logic       pd;
  logic [1:0] enc;
  logic [9:0] lpt_base;
  logic       lon, c1, c2, fon;
  logic [2:0] irq1, irq2;

  assign pd  = regs.ptr[0];
  assign enc = regs.far[1:0];

  always_comb begin
    unique case (enc)
      2'd0:    lpt_base = siocfg_pkg::LPT_BASE_0;
      2'd1:    lpt_base = regs.ctrl[siocfg_pkg::UNLOCK_BIT] ? {regs.lpt_rel, 2'b00}
                                                             : siocfg_pkg::LPT_BASE_1;
      2'd2:    lpt_base = siocfg_pkg::LPT_BASE_2;
      default: lpt_base = '0;
    endcase
  end

  assign lon = regs.fer[0] && !pd && (enc != 2'd3);
  assign c1  = regs.fer[1] && !pd;
  assign c2  = regs.fer[2] && !pd;
  assign fon = regs.fer[3] && !pd;

  // irq override register wins when its bit 0 is set
  assign irq1 = regs.irq_sel[0] ? (regs.irq_sel[2] ? siocfg_pkg::IRQ_4 : siocfg_pkg::IRQ_3)
                                : (regs.far[2] ? siocfg_pkg::IRQ_3 : siocfg_pkg::IRQ_4);
  assign irq2 = regs.irq_sel[0] ? (regs.irq_sel[6] ? siocfg_pkg::IRQ_4 : siocfg_pkg::IRQ_3)
                                : (regs.far[4] ? siocfg_pkg::IRQ_3 : siocfg_pkg::IRQ_4);

  always_comb begin
    units.lpt_on    = lon;
    units.lpt_base  = lon ? lpt_base : '0;
    units.com1_on   = c1;
    units.com1_base = c1 ? siocfg_pkg::serial_base(regs.far[3:2], regs.far[7:6]) : '0;
    units.com1_irq  = c1 ? irq1 : '0;
    units.com2_on   = c2;
    units.com2_base = c2 ? siocfg_pkg::serial_base(regs.far[5:4], regs.far[7:6]) : '0;
    units.com2_irq  = c2 ? irq2 : '0;
    units.fdc_on    = fon;
    units.fdc_base  = fon ? (regs.fer[5] ? siocfg_pkg::FDC_SEC : siocfg_pkg::FDC_PRI) : '0;
  end

endmodule

@@ rtl/superio_config_register_block.sv @@
// Top level of the super I/O configuration register block.
// Depends on siocfg_pkg, siocfg_decode and the assertion macro header.
//
// Bus accesses to an index/data port pair enter as items on the in_ channel,
// one per cycle while the result side does not stall; each yields one result
// item through the input register, then the result register. The result carries
// the read byte and the decoded unit map as it stands after that access. Data
// writes commit only on the second consecutive data-port write. The register
// file is REG_COUNT flip-flop bytes, loaded with chip defaults at reset.
`include "superio_config_register_block_assert.svh"

module superio_config_register_block #(
  parameter int REG_COUNT = 29
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic       in_port_select,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_lpt_on,
  output logic [9:0] out_lpt_base,
  output logic       out_com1_on,
  output logic [9:0] out_com1_base,
  output logic [2:0] out_com1_irq,
  output logic       out_com2_on,
  output logic [9:0] out_com2_base,
  output logic [2:0] out_com2_irq,
  output logic       out_fdc_on,
  output logic [9:0] out_fdc_base,
  output logic       out_write_taken
);

  localparam int IDX_W = $clog2(REG_COUNT);

  // input stage
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_mode_r, s1_port_r;
  logic [7:0] s1_data_r;

  // architectural state
  logic [7:0] reg_file_r [REG_COUNT];
  logic [7:0] reg_nxt    [REG_COUNT];
  logic [siocfg_pkg::IDX_BITS-1:0] sel_r, sel_nxt;
  logic       armed_r, armed_nxt;

  // result stage
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_rdata_r, rdata;
  logic       out_taken_r;
  siocfg_pkg::unit_map_t out_map_r, map_nxt;
  siocfg_pkg::cfg_view_t view_nxt;

  logic       in_fire, s1_adv, s1_fire;
  logic       commit, locked, in_range, do_store, clear_rel;
  logic       unlocked;
  logic [7:0] wval;
  logic [7:0] sid_byte, fer_byte, rel_byte;

  assign s1_adv   = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign sid_byte = reg_file_r[IDX_W'(siocfg_pkg::IDX_SID)];
  assign fer_byte = reg_file_r[IDX_W'(siocfg_pkg::IDX_FER)];
  assign rel_byte = reg_file_r[IDX_W'(siocfg_pkg::IDX_LPT_REL)];
  assign unlocked = reg_file_r[IDX_W'(siocfg_pkg::IDX_CTRL)][siocfg_pkg::UNLOCK_BIT];

  assign in_range = 32'(sel_r) < REG_COUNT;
  assign commit   = s1_mode_r && s1_port_r && armed_r;
  assign locked   = (sel_r == siocfg_pkg::IDX_LPT_REL) && !unlocked;
  assign do_store = commit && !locked && in_range && (sel_r != siocfg_pkg::IDX_SID);

  always_comb begin
    wval = s1_data_r;
    if (sel_r == siocfg_pkg::IDX_FER) begin
      if (s1_data_r == siocfg_pkg::FER_ALIAS) begin
        wval = siocfg_pkg::FER_DEFAULT;
      end
      wval = wval & siocfg_pkg::FER_MASK;
    end
  end

  // dropping the unlock bit puts the relocated base back to its default
  assign clear_rel = do_store && (sel_r == siocfg_pkg::IDX_CTRL) && unlocked
                     && !wval[siocfg_pkg::UNLOCK_BIT];

  always_comb begin
    for (int i = 0; i < REG_COUNT; i++) begin
      reg_nxt[i] = reg_file_r[i];
      if (do_store && (sel_r == 5'(i))) begin
        reg_nxt[i] = wval;
      end
      if (clear_rel && (5'(i) == siocfg_pkg::IDX_LPT_REL)) begin
        reg_nxt[i] = siocfg_pkg::LPT_REL_DEFAULT;
      end
    end
  end

  always_comb begin
    sel_nxt   = sel_r;
    armed_nxt = armed_r;
    rdata     = '0;
    if (!s1_mode_r) begin
      armed_nxt = 1'b0;
      if (!s1_port_r) begin
        rdata = 8'(sel_r);
      end else if (!in_range) begin
        rdata = siocfg_pkg::NO_REG_DATA;
      end else if (sel_r == siocfg_pkg::IDX_SID) begin
        rdata = siocfg_pkg::CHIP_ID;
      end else begin
        rdata = reg_file_r[sel_r[IDX_W-1:0]];
      end
    end else if (!s1_port_r) begin
      sel_nxt   = s1_data_r[siocfg_pkg::IDX_BITS-1:0];
      armed_nxt = 1'b0;
    end else begin
      armed_nxt = !armed_r;
    end
  end

  assign view_nxt.fer     = reg_nxt[IDX_W'(siocfg_pkg::IDX_FER)];
  assign view_nxt.far     = reg_nxt[IDX_W'(siocfg_pkg::IDX_FAR)];
  assign view_nxt.ptr     = reg_nxt[IDX_W'(siocfg_pkg::IDX_PTR)];
  assign view_nxt.lpt_rel = reg_nxt[IDX_W'(siocfg_pkg::IDX_LPT_REL)];
  assign view_nxt.ctrl    = reg_nxt[IDX_W'(siocfg_pkg::IDX_CTRL)];
  assign view_nxt.irq_sel = reg_nxt[IDX_W'(siocfg_pkg::IDX_IRQ_SEL)];

  siocfg_decode u_decode (
    .regs  (view_nxt),
    .units (map_nxt)
  );

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sel_r       <= '0;
      armed_r     <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        reg_file_r[i] <= siocfg_pkg::reg_default(5'(i));
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        sel_r   <= sel_nxt;
        armed_r <= armed_nxt;
        for (int i = 0; i < REG_COUNT; i++) begin
          reg_file_r[i] <= reg_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_mode;
      s1_port_r <= in_port_select;
      s1_data_r <= in_write_data;
    end
    if (s1_fire) begin
      out_rdata_r <= rdata;
      out_map_r   <= map_nxt;
      out_taken_r <= do_store;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_rdata_r;
  assign out_lpt_on      = out_map_r.lpt_on;
  assign out_lpt_base    = out_map_r.lpt_base;
  assign out_com1_on     = out_map_r.com1_on;
  assign out_com1_base   = out_map_r.com1_base;
  assign out_com1_irq    = out_map_r.com1_irq;
  assign out_com2_on     = out_map_r.com2_on;
  assign out_com2_base   = out_map_r.com2_base;
  assign out_com2_irq    = out_map_r.com2_irq;
  assign out_fdc_on      = out_map_r.fdc_on;
  assign out_fdc_base    = out_map_r.fdc_base;
  assign out_write_taken = out_taken_r;

  `SIOCFG_ASSERT_NEXT(a_commit_disarms, clk, rst_n, s1_fire && commit, !armed_r)
  `SIOCFG_ASSERT_SAME(a_id_fixed, clk, rst_n, 1'b1, sid_byte == siocfg_pkg::CHIP_ID)
  `SIOCFG_ASSERT_SAME(a_fer_masked, clk, rst_n, 1'b1, (fer_byte & ~siocfg_pkg::FER_MASK) == 8'h00)
  `SIOCFG_ASSERT_NEXT(a_rel_locked, clk, rst_n, !unlocked, $stable(rel_byte))

endmodule

@@ test/superio_config_register_block_tb.sv @@
// Testbench for superio_config_register_block: random index/data bus traffic with
// stalls on both sides, checked against an in-bench model of the register file and decode.
// Depends on siocfg_pkg and the block's RTL.
module superio_config_register_block_tb;
  import siocfg_pkg::*;

  localparam int REG_COUNT = 29;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  localparam logic [4:0] IDX_LAST = 5'd28;  // highest implemented register
  localparam logic [4:0] IDX_NONE = 5'h1F;  // beyond the register file

  localparam logic [9:0] ALT_A [4] = '{10'h3E8, 10'h338, 10'h2E8, 10'h220};
  localparam logic [9:0] ALT_B [4] = '{10'h2E8, 10'h238, 10'h2E0, 10'h228};

  localparam logic [4:0] HOT_IDX [8] = '{IDX_FER, IDX_FAR, IDX_PTR, IDX_SID,
                                         IDX_LPT_REL, IDX_CTRL, IDX_IRQ_SEL, IDX_LAST};

  typedef struct packed {
    logic       mode;
    logic       port;
    logic [7:0] data;
  } bus_access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       lpt_on;
    logic [9:0] lpt_base;
    logic       com1_on;
    logic [9:0] com1_base;
    logic [2:0] com1_irq;
    logic       com2_on;
    logic [9:0] com2_base;
    logic [2:0] com2_irq;
    logic       fdc_on;
    logic [9:0] fdc_base;
    logic       write_taken;
  } port_map_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_mode = 1'b0;
  logic       in_port_select = 1'b0;
  logic [7:0] in_write_data = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic       out_lpt_on;
  logic [9:0] out_lpt_base;
  logic       out_com1_on;
  logic [9:0] out_com1_base;
  logic [2:0] out_com1_irq;
  logic       out_com2_on;
  logic [9:0] out_com2_base;
  logic [2:0] out_com2_irq;
  logic       out_fdc_on;
  logic [9:0] out_fdc_base;
  logic       out_write_taken;

  superio_config_register_block #(.REG_COUNT(REG_COUNT)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_port_select (in_port_select),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_lpt_on     (out_lpt_on),
    .out_lpt_base   (out_lpt_base),
    .out_com1_on    (out_com1_on),
    .out_com1_base  (out_com1_base),
    .out_com1_irq   (out_com1_irq),
    .out_com2_on    (out_com2_on),
    .out_com2_base  (out_com2_base),
    .out_com2_irq   (out_com2_irq),
    .out_fdc_on     (out_fdc_on),
    .out_fdc_base   (out_fdc_base),
    .out_write_taken(out_write_taken)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  logic [7:0]  cfg_regs [32];
  logic [4:0]  sel_idx;
  logic        armed;

  bus_access_t bus_q [$];
  port_map_t   pending_maps [$];
  bus_access_t cur_access = '0;
  int          accepted_cnt = 0;
  int          mismatches = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  logic        hold_done = 1'b0;
  logic        tail_phase = 1'b0;

  function automatic logic [9:0] com_base(input logic [1:0] sel, input logic [1:0] ext);
    case (sel)
      2'd0:    return COM_BASE_0;
      2'd1:    return COM_BASE_1;
      2'd2:    return ALT_A[ext];
      default: return ALT_B[ext];
    endcase
  endfunction

  function automatic string map_str(input port_map_t m);
    return $sformatf("rd=%h lpt=%b/%h com1=%b/%h/%0d com2=%b/%h/%0d fdc=%b/%h wt=%b",
                     m.read_data, m.lpt_on, m.lpt_base, m.com1_on, m.com1_base,
                     m.com1_irq, m.com2_on, m.com2_base, m.com2_irq, m.fdc_on,
                     m.fdc_base, m.write_taken);
  endfunction

  // Applies one bus access to the model and returns the unit map after it.
  task automatic apply_access(input bus_access_t a, output port_map_t m);
    logic [4:0] idx;
    logic [7:0] v, old, r0, r1, r1c, ctrl;
    logic [9:0] lb;
    logic       pd, c1, c2, fon;
    logic [2:0] irq1, irq2;
    idx = sel_idx;
    v = a.data;
    m = '0;
    if (a.mode == MODE_READ) begin
      armed = 1'b0;
      if (a.port == PORT_INDEX) m.read_data = {3'b000, idx};
      else if (idx >= REG_COUNT) m.read_data = NO_REG_DATA;
      else if (idx == IDX_SID) m.read_data = CHIP_ID;
      else m.read_data = cfg_regs[idx];
    end else if (a.port == PORT_INDEX) begin
      sel_idx = v[4:0];
      armed = 1'b0;
    end else if (!armed) begin
      armed = 1'b1;
    end else begin
      armed = 1'b0;
      ctrl = cfg_regs[IDX_CTRL];
      if (idx == IDX_FER && v == FER_ALIAS) v = FER_DEFAULT;
      // relocated parallel base is locked unless the unlock bit is set
      if (!(idx == IDX_LPT_REL && !ctrl[UNLOCK_BIT]) && idx < REG_COUNT && idx != IDX_SID) begin
        old = cfg_regs[idx];
        if (idx == IDX_FER) v = v & FER_MASK;
        cfg_regs[idx] = v;
        m.write_taken = 1'b1;
        if (idx == IDX_CTRL && old[UNLOCK_BIT] && !v[UNLOCK_BIT])
          cfg_regs[IDX_LPT_REL] = LPT_REL_DEFAULT;
      end
    end

    r0 = cfg_regs[IDX_FER];
    r1 = cfg_regs[IDX_FAR];
    r1c = cfg_regs[IDX_IRQ_SEL];
    ctrl = cfg_regs[IDX_CTRL];
    pd = cfg_regs[IDX_PTR][0];
    case (r1[1:0])
      2'd0:    lb = LPT_BASE_0;
      2'd1:    lb = ctrl[UNLOCK_BIT] ? {cfg_regs[IDX_LPT_REL], 2'b00} : LPT_BASE_1;
      2'd2:    lb = LPT_BASE_2;
      default: lb = '0;
    endcase
    m.lpt_on = r0[0] && !pd && r1[1:0] != 2'd3;
    m.lpt_base = m.lpt_on ? lb : '0;

    irq1 = r1c[0] ? (r1c[2] ? IRQ_4 : IRQ_3) : (r1[2] ? IRQ_3 : IRQ_4);
    irq2 = r1c[0] ? (r1c[6] ? IRQ_4 : IRQ_3) : (r1[4] ? IRQ_3 : IRQ_4);
    c1 = r0[1] && !pd;
    c2 = r0[2] && !pd;
    fon = r0[3] && !pd;
    m.com1_on = c1;
    m.com1_base = c1 ? com_base(r1[3:2], r1[7:6]) : '0;
    m.com1_irq = c1 ? irq1 : '0;
    m.com2_on = c2;
    m.com2_base = c2 ? com_base(r1[5:4], r1[7:6]) : '0;
    m.com2_irq = c2 ? irq2 : '0;
    m.fdc_on = fon;
    m.fdc_base = fon ? (r0[5] ? FDC_SEC : FDC_PRI) : '0;
  endtask

  task automatic push_access(input logic mode, input logic port, input logic [7:0] data);
    bus_q.push_back('{mode: mode, port: port, data: data});
  endtask

  // select a register, then two data writes so the second one lands
  task automatic push_commit(input logic [4:0] idx, input logic [7:0] v);
    push_access(MODE_WRITE, PORT_INDEX, {3'($urandom_range(0, 7)), idx});
    push_access(MODE_WRITE, PORT_DATA, v);
    push_access(MODE_WRITE, PORT_DATA, v);
  endtask

  // sender
  always @(posedge clk) begin : drive
    bus_access_t nxt;
    port_map_t   want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_access(cur_access, want);
        pending_maps.push_back(want);
        accepted_cnt <= accepted_cnt + 1;
      end
      tail_phase <= (bus_q.size() <= 100);
      if (in_valid && !in_ready) begin
        // hold the offered item
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (bus_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else begin
        nxt = bus_q.pop_front();
        cur_access <= nxt;
        in_valid <= 1'b1;
        in_mode <= nxt.mode;
        in_port_select <= nxt.port;
        in_write_data <= nxt.data;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!hold_done && accepted_cnt >= 300) begin
      hold_done <= 1'b1;
      stall_left <= 199;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check
    port_map_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got.read_data = out_read_data;
      got.lpt_on = out_lpt_on;
      got.lpt_base = out_lpt_base;
      got.com1_on = out_com1_on;
      got.com1_base = out_com1_base;
      got.com1_irq = out_com1_irq;
      got.com2_on = out_com2_on;
      got.com2_base = out_com2_base;
      got.com2_irq = out_com2_irq;
      got.fdc_on = out_fdc_on;
      got.fdc_base = out_fdc_base;
      got.write_taken = out_write_taken;
      if (pending_maps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %s", map_str(got));
      end else begin
        want = pending_maps.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", map_str(want));
            $display("  actual   %s", map_str(got));
          end
        end
      end
    end
  end

  initial begin
    logic [4:0] idx;
    logic [7:0] v;
    cfg_regs = '{8'h4B, 8'h01, 8'h00, 8'h01, 8'h00, 8'h0D, 8'h00, 8'h00,
                 8'h70, 8'hC0, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h1E,
                 8'h00, 8'h00, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'hEF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    sel_idx = '0;
    armed = 1'b0;

    // directed part
    push_access(MODE_READ, PORT_INDEX, 8'hFF);
    push_access(MODE_READ, PORT_DATA, 8'h00);
    push_access(MODE_WRITE, PORT_INDEX, {3'b000, IDX_SID});
    push_access(MODE_READ, PORT_DATA, 8'hA5);
    push_access(MODE_WRITE, PORT_DATA, 8'h55);   // read-only id: never lands
    push_access(MODE_WRITE, PORT_DATA, 8'h55);
    push_commit(IDX_FER, FER_ALIAS);
    push_access(MODE_WRITE, PORT_DATA, 8'hFF);   // armed, then a read disarms
    push_access(MODE_READ, PORT_DATA, 8'hFF);
    push_commit(IDX_CTRL, 8'h40);
    push_commit(IDX_LPT_REL, 8'hFF);
    push_commit(IDX_FAR, 8'h03);                 // parallel encoding 3: off
    push_commit(IDX_CTRL, 8'h00);                // relock resets the relocated base
    push_access(MODE_WRITE, PORT_INDEX, {3'b111, IDX_LAST});
    push_access(MODE_READ, PORT_DATA, 8'h00);
    push_access(MODE_WRITE, PORT_INDEX, {3'b000, IDX_NONE});
    push_access(MODE_READ, PORT_DATA, 8'h00);

    // random part: mostly well-formed select/write/read-back sequences
    while (bus_q.size() < 1030) begin
      if ($urandom_range(0, 9) < 7) begin
        idx = ($urandom_range(0, 9) < 6) ? HOT_IDX[$urandom_range(0, 7)]
                                         : 5'($urandom_range(0, 31));
        v = 8'($urandom_range(0, 255));
        if (idx == IDX_PTR && $urandom_range(0, 4) != 0) v[0] = 1'b0;
        if (idx == IDX_FER && $urandom_range(0, 9) == 0) v = FER_ALIAS;
        if ($urandom_range(0, 9) == 0) begin
          // broken sequence: the disarming access sits between the data writes
          push_access(MODE_WRITE, PORT_INDEX, {3'($urandom_range(0, 7)), idx});
          push_access(MODE_WRITE, PORT_DATA, v);
          push_access(1'($urandom_range(0, 1)), PORT_INDEX, 8'($urandom_range(0, 255)));
          push_access(MODE_WRITE, PORT_DATA, v);
        end else begin
          push_commit(idx, v);
        end
        if ($urandom_range(0, 1) == 1)
          push_access(MODE_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        push_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (bus_q.size() != 0 || in_valid || pending_maps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_maps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
